>>> rtl/core/pesc_pkg.sv
// ----------------------------------------------------------------------------
// pesc_pkg: shared types and helpers for the per-endpoint session counter
// Holds table sizing, session range, request codes and the counter advance.
// ----------------------------------------------------------------------------
package pesc_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam logic [15:0] FIRST_SESSION = 16'd1;
  localparam logic [15:0] LAST_SESSION  = 16'd65535;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_MCAST = 1'b0,
    OP_UCAST = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } req_t;

  typedef struct packed {
    logic [15:0] session;
    logic        reboot;
  } ctr_t;

  // Wrap from the last ID back to the first and drop the reboot flag on wrap
  function automatic ctr_t advance(input ctr_t cur);
    ctr_t nxt;
    if (cur.session == LAST_SESSION) begin
      nxt.session = FIRST_SESSION;
      nxt.reboot  = 1'b0;
    end else begin
      nxt.session = cur.session + 16'd1;
      nxt.reboot  = cur.reboot;
    end
    return nxt;
  endfunction

  // Keep only the lowest set bit
  function automatic logic [TABLE_DEPTH-1:0] lowest_one(input logic [TABLE_DEPTH-1:0] x);
    return x & (~x + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  endfunction

endpackage

>>> rtl/core/pesc_if.sv
// ----------------------------------------------------------------------------
// pesc_if: request and response channels
// Valid/ready channels carrying a session request and its response.
// ----------------------------------------------------------------------------
interface pesc_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output command, output addr_high, output addr_low,
                  input ready);
  modport sink   (input valid, input command, input addr_high, input addr_low,
                  output ready);
endinterface

interface pesc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] session_id;
  logic        reboot_flag;
  logic        table_full;

  modport source (output valid, output session_id, output reboot_flag,
                  output table_full, input ready);
  modport sink   (input valid, input session_id, input reboot_flag,
                  input table_full, output ready);
endinterface

>>> rtl/core/pesc_front.sv
// ----------------------------------------------------------------------------
// pesc_front: request intake
// Registers an incoming transaction, decodes its command and pushes it on.
// ----------------------------------------------------------------------------
module pesc_front import pesc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pesc_req_if.sink req_i,
  input  logic q_full_i,
  output logic push_o,
  output req_t push_data_o
);

  logic front_valid_q, front_valid_d;
  req_t front_req_q;
  logic accept;

  assign req_i.ready = !front_valid_q || !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign push_o      = front_valid_q && !q_full_i;
  assign push_data_o = front_req_q;

  always_comb begin
    front_valid_d = front_valid_q;
    if (push_o) front_valid_d = 1'b0;
    if (accept) front_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else begin
      front_valid_q <= front_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_req_q.op        <= req_i.command ? OP_UCAST : OP_MCAST;
      front_req_q.addr_high <= req_i.addr_high;
      front_req_q.addr_low  <= req_i.addr_low;
    end
  end

endmodule

>>> rtl/core/pesc_queue.sv
// ----------------------------------------------------------------------------
// pesc_queue: request queue
// Short FIFO between intake and table update so each side stalls on its own.
// ----------------------------------------------------------------------------
module pesc_queue import pesc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output req_t pop_data_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  req_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> rtl/core/pesc_back.sv
// ----------------------------------------------------------------------------
// pesc_back: session table and response register
// Matches a unicast address against all entries and allocates or advances its counter; multicast advances its own.
// ----------------------------------------------------------------------------
module pesc_back import pesc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  req_t q_data_i,
  output logic pop_o,
  pesc_rsp_if.source rsp_o
);

  logic [TABLE_DEPTH-1:0] entry_valid_q, entry_valid_d;
  logic [63:0]            entry_addr_high_q [TABLE_DEPTH];
  logic [63:0]            entry_addr_low_q  [TABLE_DEPTH];
  ctr_t                   entry_ctr_q       [TABLE_DEPTH];
  ctr_t                   mcast_ctr_q, mcast_ctr_d;

  logic [TABLE_DEPTH-1:0] match, hit_oh, free_oh, sel_oh;
  logic                   hit_any, free_any, full;
  ctr_t                   sel_ctr, cur_ctr;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_session_q;
  logic        out_reboot_q, out_full_q;
  logic        is_ucast;

  assign pop_o    = q_valid_i && (!out_valid_q || rsp_o.ready);
  assign is_ucast = (q_data_i.op == OP_UCAST);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = entry_valid_q[i] && (entry_addr_high_q[i] == q_data_i.addr_high)
                 && (entry_addr_low_q[i] == q_data_i.addr_low);
    end
  end

  assign hit_oh   = lowest_one(match);
  assign free_oh  = lowest_one(~entry_valid_q);
  assign hit_any  = |match;
  assign free_any = !(&entry_valid_q);
  assign full     = !hit_any && !free_any;
  assign sel_oh   = hit_any ? hit_oh : free_oh;

  always_comb begin
    sel_ctr = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_oh[i]) sel_ctr = sel_ctr | entry_ctr_q[i];
    end
  end

  // A fresh slot starts at the first ID with the reboot flag set
  always_comb begin
    if (!is_ucast) begin
      cur_ctr = mcast_ctr_q;
    end else if (hit_any) begin
      cur_ctr = sel_ctr;
    end else begin
      cur_ctr.session = FIRST_SESSION;
      cur_ctr.reboot  = 1'b1;
    end
  end

  always_comb begin
    mcast_ctr_d   = mcast_ctr_q;
    entry_valid_d = entry_valid_q;
    out_valid_d   = out_valid_q;
    if (rsp_o.ready) out_valid_d = 1'b0;
    if (pop_o) begin
      out_valid_d = 1'b1;
      if (!is_ucast) begin
        mcast_ctr_d = advance(mcast_ctr_q);
      end else if (!full) begin
        entry_valid_d = entry_valid_q | sel_oh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcast_ctr_q.session <= FIRST_SESSION;
      mcast_ctr_q.reboot  <= 1'b1;
      entry_valid_q       <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      mcast_ctr_q   <= mcast_ctr_d;
      entry_valid_q <= entry_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_ucast && !full) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (sel_oh[i]) begin
          entry_ctr_q[i] <= advance(cur_ctr);
          if (!hit_any) begin
            entry_addr_high_q[i] <= q_data_i.addr_high;
            entry_addr_low_q[i]  <= q_data_i.addr_low;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_session_q <= (is_ucast && full) ? 16'd0 : cur_ctr.session;
      out_reboot_q  <= (is_ucast && full) ? 1'b0 : cur_ctr.reboot;
      out_full_q    <= is_ucast && full;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.session_id  = out_session_q;
  assign rsp_o.reboot_flag = out_reboot_q;
  assign rsp_o.table_full  = out_full_q;

endmodule

>>> rtl/core/per_endpoint_session_counter.sv
// ----------------------------------------------------------------------------
// per_endpoint_session_counter: session ID and reboot flag allocator
// Hands out session IDs per destination address or for multicast.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transaction: command 0 asks for the next
//   multicast session, command 1 for the next unicast session of the 128-bit
//   address in addr_high/addr_low. rsp_o returns one transaction per request,
//   in order: session_id, reboot_flag and table_full.
//   A request passes an intake register, a two-entry queue, and the table
//   stage that matches all 16 entries in parallel and updates the selected
//   counter in the same cycle.
//   Throughput is one request per cycle while the receiver keeps rsp_o.ready
//   high, limited by the single table read-modify-write stage.
//   A new address takes the lowest free slot; when none is free the response
//   is ID 0, flag 0 and table_full 1, with no table change.
//   Reset clears every table entry and restarts the multicast counter at the
//   first ID with the reboot flag set.
//   When the receiver stalls, the response register holds, the queue fills,
//   and req_i.ready drops once the intake register is also occupied.
// ----------------------------------------------------------------------------
module per_endpoint_session_counter import pesc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pesc_req_if.sink   req_i,
  pesc_rsp_if.source rsp_o
);

  logic q_full, q_push, q_valid, q_pop;
  req_t push_data, pop_data;

  pesc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (push_data)
  );

  pesc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data)
  );

  pesc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (pop_data),
    .pop_o     (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

>>> sim/session_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_checker: scoreboard for the per-endpoint session counter
// Watches both channels. Each accepted request is run through a local model of
// the multicast counter and the address table. Each accepted response is then
// compared with the oldest predicted grant.
// ----------------------------------------------------------------------------
module session_checker import pesc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pesc_req_if  req_mon,
  pesc_rsp_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [15:0] id;
    logic        reboot;
    logic        full;
  } grant_t;

  grant_t      due_grants[$];
  logic [15:0] mc_id;
  logic        mc_reboot;
  logic        slot_used   [TABLE_DEPTH];
  logic [63:0] slot_hi     [TABLE_DEPTH];
  logic [63:0] slot_lo     [TABLE_DEPTH];
  logic [15:0] slot_id     [TABLE_DEPTH];
  logic        slot_reboot [TABLE_DEPTH];

  // Step a counter: the last ID goes back to the first and drops the reboot flag
  function automatic logic [16:0] bump(input logic [15:0] id, input logic reboot);
    if (id == LAST_SESSION) begin
      return {FIRST_SESSION, 1'b0};
    end
    return {id + 16'd1, reboot};
  endfunction

  // Work out the grant for one request and update the local table
  function automatic grant_t take_grant(input logic cmd, input logic [63:0] hi,
                                        input logic [63:0] lo);
    grant_t g;
    int     hit;
    int     free;
    hit  = -1;
    free = -1;
    g    = '0;
    if (cmd == OP_MCAST) begin
      g.id     = mc_id;
      g.reboot = mc_reboot;
      {mc_id, mc_reboot} = bump(mc_id, mc_reboot);
      return g;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (slot_used[k] && slot_hi[k] == hi && slot_lo[k] == lo && hit < 0) begin
        hit = k;
      end
      if (!slot_used[k] && free < 0) begin
        free = k;
      end
    end
    if (hit < 0) begin
      if (free < 0) begin
        g.full = 1'b1;
        return g;
      end
      hit              = free;
      slot_used[hit]   = 1'b1;
      slot_hi[hit]     = hi;
      slot_lo[hit]     = lo;
      slot_id[hit]     = FIRST_SESSION;
      slot_reboot[hit] = 1'b1;
    end
    g.id     = slot_id[hit];
    g.reboot = slot_reboot[hit];
    {slot_id[hit], slot_reboot[hit]} = bump(slot_id[hit], slot_reboot[hit]);
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t seen;
    grant_t want;
    if (!rst_ni) begin
      due_grants.delete();
      mc_id        = FIRST_SESSION;
      mc_reboot    = 1'b1;
      fail_count_o = 0;
      pending_o    = 0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        slot_used[k] = 1'b0;
      end
    end else begin
      // Compare first so a response never meets a grant predicted at this edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.id     = rsp_mon.session_id;
        seen.reboot = rsp_mon.reboot_flag;
        seen.full   = rsp_mon.table_full;
        if (due_grants.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected response id %0d reboot %0b full %0b", $time,
                   seen.id, seen.reboot, seen.full);
        end else begin
          want = due_grants.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            $display("%0t: expected id %0d rb %0b full %0b, got id %0d rb %0b full %0b",
                     $time, want.id, want.reboot, want.full, seen.id, seen.reboot,
                     seen.full);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        due_grants.push_back(take_grant(req_mon.command, req_mon.addr_high,
                                        req_mon.addr_low));
      end
      pending_o = due_grants.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the per-endpoint session counter
// Drives directed and random session requests with varied idling on both
// channels. The scoreboard predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top import pesc_pkg::*;;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 155;
  localparam int SETTLE_TICKS = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  logic [63:0] known_hi[$];
  logic [63:0] known_lo[$];

  pesc_req_if req_if ();
  pesc_rsp_if rsp_if ();

  per_endpoint_session_counter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  session_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one transaction, idling first at random; return at the accepting edge
  task automatic send_req(input op_e op, input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= op;
    req_if.addr_high <= hi;
    req_if.addr_low  <= lo;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic alloc_addr(input logic [63:0] hi, input logic [63:0] lo);
    known_hi.push_back(hi);
    known_lo.push_back(lo);
    send_req(OP_UCAST, hi, lo);
  endtask

  // Hold the request channel idle until every response has come back
  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random();
    int          pick;
    int          idx;
    int          bitpos;
    logic [63:0] hi;
    logic [63:0] lo;
    pick = $urandom_range(99);
    idx  = $urandom_range(known_hi.size() - 1);
    hi   = {$urandom, $urandom};
    lo   = {$urandom, $urandom};
    if (pick < 35) begin
      send_req(OP_MCAST, hi, lo);
    end else if (pick < 75) begin
      send_req(OP_UCAST, known_hi[idx], known_lo[idx]);
    end else if (pick < 87) begin
      // Near miss: one address bit off from a stored entry
      bitpos = $urandom_range(127);
      hi     = known_hi[idx];
      lo     = known_lo[idx];
      if (bitpos < 64) begin
        hi = hi ^ (64'd1 << bitpos);
      end else begin
        lo = lo ^ (64'd1 << (bitpos - 64));
      end
      send_req(OP_UCAST, hi, lo);
    end else begin
      send_req(OP_UCAST, hi, lo);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.command   = OP_MCAST;
    req_if.addr_high = '0;
    req_if.addr_low  = '0;
    rsp_if.ready     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: allocate, hit, fill the table, then overflow it
    send_req(OP_MCAST, '0, '0);
    alloc_addr('0, '0);
    send_req(OP_UCAST, '0, '0);
    alloc_addr('1, '1);
    alloc_addr('0, '1);
    alloc_addr('1, '0);
    alloc_addr(64'd0, 64'd1);
    alloc_addr(64'h8000_0000_0000_0000, 64'd0);
    send_req(OP_MCAST, '1, '1);
    send_req(OP_UCAST, '1, '1);
    while (known_hi.size() < TABLE_DEPTH) begin
      alloc_addr({$urandom, $urandom}, {$urandom, $urandom});
    end
    send_req(OP_UCAST, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_req(OP_UCAST, '0, '0);
    send_req(OP_UCAST, {$urandom, $urandom}, {$urandom, $urandom});
    send_req(OP_MCAST, {$urandom, $urandom}, {$urandom, $urandom});
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 57 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 34 : 0;
      repeat (PHASE_ITEMS) send_random();
      drain();
    end
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
